/* hdl/ufrc_pkg.sv */
`default_nettype none

package ufrc_pkg;

	// Field widths of the command and result transfers
	localparam int NODE_W  = 6;
	localparam int COUNT_W = 7;
	localparam int RANK_W  = 3;

	localparam logic [RANK_W-1:0]  RANK_MAX         = 3'd7;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 7'd64;
	localparam int                 MAX_NODES_DEFAULT = 64;

	// Opcodes
	localparam logic OP_UNION = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} ufrc_cmd_t;

	typedef struct packed {
		logic [NODE_W-1:0]  root_a;
		logic [NODE_W-1:0]  root_b;
		logic               merged;
		logic               same_set;
		logic [COUNT_W-1:0] set_total;
		logic               all_joined;
		logic               bad_node;
	} ufrc_res_t;

	// Largest node count the store can hold, in the count width
	function automatic logic [COUNT_W-1:0] count_cap(input int max_nodes);
		logic [COUNT_W-1:0] cap;
		if (max_nodes >= (1 << COUNT_W)) begin
			cap = '1;
		end else begin
			cap = COUNT_W'(max_nodes);
		end
		return cap;
	endfunction

	// Node count in use: held to 1..cap
	function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v,
		input logic [COUNT_W-1:0] cap);
		logic [COUNT_W-1:0] r;
		if (v == '0) begin
			r = COUNT_W'(1);
		end else if (v > cap) begin
			r = cap;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hdl/ufrc_mem.sv */
`default_nettype none

// Node table: one write port, one read port, registered read data
module ufrc_mem #(
	parameter int DEPTH = 64,
	parameter int AW    = 6,
	parameter int DW    = 9
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [DW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] store_q [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[waddr] <= wdata;
		end
		rdata_q <= store_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/ufrc_ctrl.sv */
`default_nettype none

// Sequencer: root walks, path rewrites, linking and the set count
module ufrc_ctrl #(
	parameter int MAX_NODES = ufrc_pkg::MAX_NODES_DEFAULT,
	parameter int NW        = $clog2(MAX_NODES),
	parameter int MW        = NW + ufrc_pkg::RANK_W
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire ufrc_pkg::ufrc_cmd_t                cmd,
	input  wire logic                               restart,
	input  wire logic [ufrc_pkg::COUNT_W-1:0]       restart_count,
	input  wire logic [ufrc_pkg::COUNT_W-1:0]       limit,
	output logic                                    busy,
	output logic                                    done,
	output ufrc_pkg::ufrc_res_t                     result,
	output logic                                    mem_we,
	output logic      [NW-1:0]                      mem_waddr,
	output logic      [MW-1:0]                      mem_wdata,
	output logic      [NW-1:0]                      mem_raddr,
	input  wire logic [MW-1:0]                      mem_rdata
);

	localparam int NODE_W  = ufrc_pkg::NODE_W;
	localparam int COUNT_W = ufrc_pkg::COUNT_W;
	localparam int RANK_W  = ufrc_pkg::RANK_W;

	localparam logic [NW-1:0]      LAST_NODE = NW'(MAX_NODES - 1);
	localparam logic [COUNT_W-1:0] CAP       = ufrc_pkg::count_cap(MAX_NODES);
	localparam logic [COUNT_W-1:0] RST_COUNT =
		ufrc_pkg::clamp_count(ufrc_pkg::NODE_COUNT_RESET, CAP);

	// Sequencer states
	localparam logic [2:0] S_CLR  = 3'd0;
	localparam logic [2:0] S_IDLE = 3'd1;
	localparam logic [2:0] S_WALK = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_LINK = 3'd4;
	localparam logic [2:0] S_BUMP = 3'd5;

	logic [2:0]         state_q, state_d;
	logic [NW-1:0]      clr_q, clr_d;
	logic               op_q, op_d;
	logic [NW-1:0]      a_q, a_d, b_q, b_d;
	logic               sel_q, sel_d;
	logic [NW-1:0]      cur_q, cur_d;
	logic [NW-1:0]      ra_q, ra_d, rb_q, rb_d;
	logic [RANK_W-1:0]  rka_q, rka_d, rkb_q, rkb_d;
	logic [COUNT_W-1:0] cnt_q, cnt_d;
	logic               done_q;
	ufrc_pkg::ufrc_res_t result_q, res_d;
	logic               emit;
	logic               phase_end;

	logic [NW-1:0]      link;
	logic [RANK_W-1:0]  rd_rank;
	logic [NW-1:0]      node_sel;
	logic [NW-1:0]      root_sel;
	logic [NW-1:0]      in_a, in_b;
	logic               in_bad;
	logic [RANK_W-1:0]  rkb_inc;

	assign link     = mem_rdata[NW-1:0];
	assign rd_rank  = mem_rdata[MW-1:NW];
	assign node_sel = sel_q ? b_q : a_q;
	assign root_sel = sel_q ? rb_q : ra_q;
	assign in_a     = NW'(cmd.node_a);
	assign in_b     = NW'(cmd.node_b);
	assign in_bad   = ({1'b0, cmd.node_a} >= limit) || ({1'b0, cmd.node_b} >= limit);
	assign rkb_inc  = (rkb_q == ufrc_pkg::RANK_MAX) ? rkb_q : rkb_q + 1'b1;

	// Next-state and table access
	always_comb begin
		state_d   = state_q;
		clr_d     = clr_q;
		op_d      = op_q;
		a_d       = a_q;
		b_d       = b_q;
		sel_d     = sel_q;
		cur_d     = cur_q;
		ra_d      = ra_q;
		rb_d      = rb_q;
		rka_d     = rka_q;
		rkb_d     = rkb_q;
		cnt_d     = cnt_q;
		mem_we    = 1'b0;
		mem_waddr = cur_q;
		mem_wdata = {rd_rank, root_sel};
		mem_raddr = cur_q;
		emit      = 1'b0;
		phase_end = 1'b0;
		res_d     = '0;

		unique case (state_q)
			S_CLR: begin
				// every node its own root, rank zero
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = {{RANK_W{1'b0}}, clr_q};
				clr_d     = clr_q + 1'b1;
				if (clr_q == LAST_NODE) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (in_bad) begin
						emit            = 1'b1;
						res_d.set_total = cnt_q;
						res_d.all_joined = (cnt_q == COUNT_W'(1));
						res_d.bad_node  = 1'b1;
					end else begin
						op_d      = cmd.opcode;
						a_d       = in_a;
						b_d       = in_b;
						sel_d     = 1'b0;
						mem_raddr = in_a;
						cur_d     = in_a;
						state_d   = S_WALK;
					end
				end
			end
			S_WALK: begin
				if (link == cur_q) begin
					// root reached; its rank comes with the same word
					if (sel_q) begin
						rb_d  = cur_q;
						rkb_d = rd_rank;
					end else begin
						ra_d  = cur_q;
						rka_d = rd_rank;
					end
					if (node_sel == cur_q) begin
						phase_end = 1'b1;
					end else begin
						mem_raddr = node_sel;
						cur_d     = node_sel;
						state_d   = S_CMP;
					end
				end else begin
					mem_raddr = link;
					cur_d     = link;
				end
			end
			S_CMP: begin
				// repoint this path node at the root, keep its rank
				mem_we    = 1'b1;
				mem_waddr = cur_q;
				mem_wdata = {rd_rank, root_sel};
				if (link == root_sel) begin
					phase_end = 1'b1;
				end else begin
					mem_raddr = link;
					cur_d     = link;
				end
			end
			S_LINK: begin
				res_d.root_a   = NODE_W'(ra_q);
				res_d.root_b   = NODE_W'(rb_q);
				res_d.same_set = (ra_q == rb_q);
				if (op_q == ufrc_pkg::OP_QUERY || ra_q == rb_q) begin
					emit    = 1'b1;
					state_d = S_IDLE;
				end else begin
					res_d.merged = 1'b1;
					if (cnt_q > COUNT_W'(1)) begin
						cnt_d = cnt_q - 1'b1;
					end
					mem_we = 1'b1;
					if (rka_q > rkb_q) begin
						mem_waddr = rb_q;
						mem_wdata = {rkb_q, ra_q};
						emit      = 1'b1;
						state_d   = S_IDLE;
					end else begin
						mem_waddr = ra_q;
						mem_wdata = {rka_q, rb_q};
						if (rka_q < rkb_q) begin
							emit    = 1'b1;
							state_d = S_IDLE;
						end else begin
							state_d = S_BUMP;
						end
					end
				end
				res_d.set_total  = cnt_d;
				res_d.all_joined = (cnt_d == COUNT_W'(1));
			end
			S_BUMP: begin
				// equal ranks: the surviving root grows one level
				mem_we           = 1'b1;
				mem_waddr        = rb_q;
				mem_wdata        = {rkb_inc, rb_q};
				emit             = 1'b1;
				res_d.root_a     = NODE_W'(ra_q);
				res_d.root_b     = NODE_W'(rb_q);
				res_d.merged     = 1'b1;
				res_d.set_total  = cnt_q;
				res_d.all_joined = (cnt_q == COUNT_W'(1));
				state_d          = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		// end of a find: move on to the second node, or to linking
		if (phase_end) begin
			if (!sel_q) begin
				sel_d     = 1'b1;
				mem_raddr = b_q;
				cur_d     = b_q;
				state_d   = S_WALK;
			end else begin
				state_d = S_LINK;
			end
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= RST_COUNT;
			done_q  <= 1'b0;
		end else if (restart) begin
			state_q <= S_CLR;
			clr_q   <= '0;
			cnt_q   <= restart_count;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			cnt_q   <= cnt_d;
			done_q  <= emit;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		op_q  <= op_d;
		a_q   <= a_d;
		b_q   <= b_d;
		sel_q <= sel_d;
		cur_q <= cur_d;
		ra_q  <= ra_d;
		rb_q  <= rb_d;
		rka_q <= rka_d;
		rkb_q <= rkb_d;
		if (emit) begin
			result_q <= res_d;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) && (cnt_q <= limit))
		else $error("set count out of range");

	a_cmp_not_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CMP) |-> (cur_q != root_sel))
		else $error("path rewrite reached the root");

	a_merge_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.merged) |-> (!result_q.same_set && !result_q.bad_node))
		else $error("merge reported with same set or bad node");

	a_accept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(start && state_q == S_IDLE) |=> (state_q != S_IDLE || done_q))
		else $error("accepted command neither started nor answered");

	a_bump_after_link: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BUMP) |-> ($past(state_q) == S_LINK))
		else $error("rank bump without link");

endmodule

`default_nettype wire

/* hdl/union_find_rank_compress.sv */
// Disjoint-set store with union by rank and path compression.
// Command channel: cmd (opcode, node_a, node_b) is transferred at a rising
// edge with start high and busy low. opcode union joins the two sets, query
// only reports; both compress the walked paths.
// Result channel: result is valid for exactly one cycle while done is high.
// There is no back-pressure; the receiver must take it in that cycle.
// Sequence: a command with a node at or above node_count is answered in the
// cycle after its transfer. Otherwise each find walks the links from the node
// to its root (depth at most log2 of the node count), then rewrites the path,
// if any, onto that root; a link step follows, plus a rank bump step when two
// equal-rank roots meet. done rises together with the registered result.
// The pace is set by the node table's one read port: one link read per cycle.
// Configuration: cfg_we with cfg_wdata writes node_count (clamped to
// 1..MAX_NODES) and restarts the store.
// Reset and every node_count write start a clearing pass over all MAX_NODES
// table entries that resets all links and ranks; busy is high throughout.
`default_nettype none

module union_find_rank_compress #(
	parameter int MAX_NODES = ufrc_pkg::MAX_NODES_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire ufrc_pkg::ufrc_cmd_t          cmd,
	output logic                              busy,
	output logic                              done,
	output ufrc_pkg::ufrc_res_t               result,
	input  wire logic                         cfg_we,
	input  wire logic [ufrc_pkg::COUNT_W-1:0] cfg_wdata
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int MW = NW + ufrc_pkg::RANK_W;
	localparam logic [ufrc_pkg::COUNT_W-1:0] CAP = ufrc_pkg::count_cap(MAX_NODES);

	logic [ufrc_pkg::COUNT_W-1:0] node_count_q;
	logic [ufrc_pkg::COUNT_W-1:0] limit;
	logic [ufrc_pkg::COUNT_W-1:0] restart_count;

	logic          mem_we;
	logic [NW-1:0] mem_waddr;
	logic [MW-1:0] mem_wdata;
	logic [NW-1:0] mem_raddr;
	logic [MW-1:0] mem_rdata;

	// node_count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= ufrc_pkg::NODE_COUNT_RESET;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Count in use and restart value
	assign limit         = ufrc_pkg::clamp_count(node_count_q, CAP);
	assign restart_count = ufrc_pkg::clamp_count(cfg_wdata, CAP);

	ufrc_ctrl #(
		.MAX_NODES (MAX_NODES),
		.NW        (NW),
		.MW        (MW)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.cmd           (cmd),
		.restart       (cfg_we),
		.restart_count (restart_count),
		.limit         (limit),
		.busy          (busy),
		.done          (done),
		.result        (result),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	ufrc_mem #(
		.DEPTH (MAX_NODES),
		.AW    (NW),
		.DW    (MW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire
